// ===== hdl/i2cmrt_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmrt_pkg
// Shared types and codes of the I2C master register transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmrt_pkg;

  // Largest transfer in data bytes, and the size of the write buffer.
  localparam int MAX_BYTES = 8;
  localparam int BUF_AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  // Byte counters follow the four-bit count fields of the item formats.
  localparam int CNT_W = 4;
  localparam int DEFAULT_ATTEMPTS = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Item function codes.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_EVENT = 2'd3;

  // Bus engine status codes.
  localparam logic [2:0] ST_START     = 3'd0;
  localparam logic [2:0] ST_REPSTART  = 3'd1;
  localparam logic [2:0] ST_ADDR_ACK  = 3'd2;
  localparam logic [2:0] ST_ADDR_NACK = 3'd3;
  localparam logic [2:0] ST_DATA_ACK  = 3'd4;
  localparam logic [2:0] ST_DATA_NACK = 3'd5;
  localparam logic [2:0] ST_ARB_LOST  = 3'd6;

  // Bus engine commands.
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_SEND   = 3'd2;
  localparam logic [2:0] CMD_RXACK  = 3'd3;
  localparam logic [2:0] CMD_RXNACK = 3'd4;
  localparam logic [2:0] CMD_STOP   = 3'd5;

  // Completion error codes.
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_START     = 3'd1;
  localparam logic [2:0] ERR_RESTART   = 3'd2;
  localparam logic [2:0] ERR_SEND      = 3'd3;
  localparam logic [2:0] ERR_READ      = 3'd4;
  localparam logic [2:0] ERR_ATTEMPTS  = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_EVENT
  } op_kind_e;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [3:0] byte_count;
    logic [2:0] load_index;
    logic [7:0] load_byte;
    logic [2:0] bus_status;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [2:0] rx_index;
    logic       done_res;
    logic [3:0] transferred;
    logic [2:0] error_code;
    logic       busy_res;
  } out_item_t;

  // Classified item as it travels from the front end to the sequencer.
  typedef struct packed {
    op_kind_e         kind;
    logic             is_read;
    logic [6:0]       address;
    logic [7:0]       register;
    logic [CNT_W-1:0] count;
    logic             load_en;
    logic [2:0]       slot;
    logic [7:0]       data;
    logic [2:0]       status;
  } op_t;

endpackage

// ===== hdl/i2cmrt_front.sv =====
// ----------------------------------------------------------------------------
// i2cmrt_front
// Accepts input items and classifies them into loads, starts and bus events.
// ----------------------------------------------------------------------------
module i2cmrt_front import i2cmrt_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     push_o,
  input  logic     q_ready_i,
  output op_t      op_o
);

  logic [CNT_W-1:0] count_sat;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  // Counts beyond the buffer size are clipped to the buffer size.
  assign count_sat = (int'(in_data_i.byte_count) > MAX_BYTES) ? CNT_W'(MAX_BYTES)
                                                              : in_data_i.byte_count;

  always_comb begin
    op_o          = '0;
    op_o.is_read  = (in_data_i.func == FUNC_READ);
    op_o.address  = in_data_i.device_address;
    op_o.register = in_data_i.register_address;
    op_o.count    = count_sat;
    op_o.slot     = in_data_i.load_index;
    op_o.load_en  = (int'(in_data_i.load_index) < MAX_BYTES);
    op_o.status   = in_data_i.bus_status;
    unique case (in_data_i.func)
      FUNC_LOAD: begin
        op_o.kind = OP_LOAD;
        op_o.data = in_data_i.load_byte;
      end
      FUNC_READ, FUNC_WRITE: begin
        op_o.kind = OP_START;
      end
      default: begin
        op_o.kind = OP_EVENT;
        op_o.data = in_data_i.rx_byte;
      end
    endcase
  end

endmodule

// ===== hdl/i2cmrt_queue.sv =====
// ----------------------------------------------------------------------------
// i2cmrt_queue
// Short queue of classified items between the front end and the sequencer.
// ----------------------------------------------------------------------------
module i2cmrt_queue import i2cmrt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_data_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  pop_data_o
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]       count_q, count_d;
  logic                do_push, do_pop;

  assign ready_o    = (count_q != CW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/i2cmrt_back.sv =====
// ----------------------------------------------------------------------------
// i2cmrt_back
// Transfer sequencer: runs the phase logic on queued items, keeps the write
// buffer and the attempt limit, and holds the result in an output register.
// ----------------------------------------------------------------------------
module i2cmrt_back import i2cmrt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [3:0] cfg_data_i,
  input  logic      q_valid_i,
  input  op_t       op_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_SLAW    = 3'd2;
  localparam logic [2:0] PH_REG     = 3'd3;
  localparam logic [2:0] PH_RESTART = 3'd4;
  localparam logic [2:0] PH_SLAR    = 3'd5;
  localparam logic [2:0] PH_RX      = 3'd6;
  localparam logic [2:0] PH_TXDATA  = 3'd7;

  logic [2:0]       phase_q, phase_d;
  logic             is_read_q, is_read_d;
  logic [3:0]       attempt_q, attempt_d;
  logic [3:0]       max_q;
  logic [6:0]       addr_q, addr_d;
  logic [7:0]       reg_q, reg_d;
  logic [CNT_W-1:0] left_q, left_d, total_q, total_d, pos_q, pos_d;
  logic [7:0]       wbuf_q [MAX_BYTES];
  logic             out_valid_q;
  out_item_t        out_q, res;

  logic             ok, nack, st_start, st_arb;
  logic [CNT_W-1:0] pos_inc, left_dec;
  logic [7:0]       wbuf_byte;

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ok       = (op_i.status == ST_ADDR_ACK) || (op_i.status == ST_DATA_ACK);
  assign nack     = (op_i.status == ST_ADDR_NACK) || (op_i.status == ST_DATA_NACK);
  assign st_start = (op_i.status == ST_START) || (op_i.status == ST_REPSTART);
  assign st_arb   = (op_i.status == ST_ARB_LOST);
  assign pos_inc  = pos_q + 1'b1;
  assign left_dec = (left_q != '0) ? left_q - 1'b1 : '0;
  // Byte sent for the next data phase, taken at the advanced position.
  assign wbuf_byte = (int'(pos_inc) < MAX_BYTES) ? wbuf_q[BUF_AW'(pos_inc)] : 8'h00;

  always_comb begin
    phase_d   = phase_q;
    is_read_d = is_read_q;
    attempt_d = attempt_q;
    addr_d    = addr_q;
    reg_d     = reg_q;
    left_d    = left_q;
    total_d   = total_q;
    pos_d     = pos_q;
    res       = '0;
    if (pop_o) begin
      unique case (op_i.kind)
        OP_LOAD: begin
        end
        OP_START: begin
          if (phase_q == PH_IDLE) begin
            is_read_d = op_i.is_read;
            addr_d    = op_i.address;
            reg_d     = op_i.register;
            total_d   = op_i.count;
            left_d    = op_i.count;
            pos_d     = '0;
            if (max_q == '0) begin
              attempt_d        = '0;
              res.done_res     = 1'b1;
              res.error_code   = ERR_ATTEMPTS;
              phase_d          = PH_IDLE;
            end else begin
              attempt_d       = 4'd1;
              phase_d         = PH_START;
              res.bus_command = CMD_START;
            end
          end
        end
        OP_EVENT: begin
          // A reopen (arbitration loss or retry) restarts the byte counters.
          unique case (phase_q)
            PH_IDLE: begin
            end
            PH_START: begin
              if (st_start) begin
                phase_d         = PH_SLAW;
                res.bus_command = CMD_SEND;
                res.tx_byte     = {addr_q, 1'b0};
              end else if (st_arb) begin
                left_d = total_q; pos_d = '0; phase_d = PH_START;
                res.bus_command = CMD_START;
              end else begin
                phase_d = PH_IDLE; res.done_res = 1'b1; res.error_code = ERR_START;
              end
            end
            PH_SLAW: begin
              if (ok) begin
                phase_d         = PH_REG;
                res.bus_command = CMD_SEND;
                res.tx_byte     = reg_q;
              end else if (nack) begin
                if (attempt_q >= max_q) begin
                  phase_d = PH_IDLE; res.done_res = 1'b1; res.error_code = ERR_ATTEMPTS;
                end else begin
                  attempt_d = attempt_q + 1'b1;
                  left_d = total_q; pos_d = '0; phase_d = PH_START;
                  res.bus_command = CMD_START;
                end
              end else if (st_arb) begin
                left_d = total_q; pos_d = '0; phase_d = PH_START;
                res.bus_command = CMD_START;
              end else begin
                phase_d = PH_IDLE; res.bus_command = CMD_STOP;
                res.done_res = 1'b1; res.error_code = ERR_SEND;
              end
            end
            PH_REG: begin
              if (ok) begin
                if (is_read_q) begin
                  phase_d         = PH_RESTART;
                  res.bus_command = CMD_START;
                end else if (left_q != '0) begin
                  phase_d         = PH_TXDATA;
                  res.bus_command = CMD_SEND;
                  res.tx_byte     = (int'(pos_q) < MAX_BYTES) ? wbuf_q[BUF_AW'(pos_q)]
                                                             : 8'h00;
                end else begin
                  phase_d = PH_IDLE; res.bus_command = CMD_STOP; res.done_res = 1'b1;
                end
              end else if (nack) begin
                phase_d = PH_IDLE; res.bus_command = CMD_STOP; res.done_res = 1'b1;
              end else if (st_arb) begin
                left_d = total_q; pos_d = '0; phase_d = PH_START;
                res.bus_command = CMD_START;
              end else begin
                phase_d = PH_IDLE; res.bus_command = CMD_STOP;
                res.done_res = 1'b1; res.error_code = ERR_SEND;
              end
            end
            PH_RESTART: begin
              if (st_start) begin
                phase_d         = PH_SLAR;
                res.bus_command = CMD_SEND;
                res.tx_byte     = {addr_q, 1'b1};
              end else if (st_arb) begin
                left_d = total_q; pos_d = '0; phase_d = PH_START;
                res.bus_command = CMD_START;
              end else begin
                phase_d = PH_IDLE; res.bus_command = CMD_STOP;
                res.done_res = 1'b1; res.error_code = ERR_RESTART;
              end
            end
            PH_SLAR: begin
              if (ok) begin
                if (left_q != '0) begin
                  phase_d         = PH_RX;
                  res.bus_command = (left_q == CNT_W'(1)) ? CMD_RXNACK : CMD_RXACK;
                end else begin
                  phase_d = PH_IDLE; res.bus_command = CMD_STOP; res.done_res = 1'b1;
                end
              end else if (nack) begin
                phase_d = PH_IDLE; res.bus_command = CMD_STOP; res.done_res = 1'b1;
              end else if (st_arb) begin
                left_d = total_q; pos_d = '0; phase_d = PH_START;
                res.bus_command = CMD_START;
              end else begin
                phase_d = PH_IDLE; res.bus_command = CMD_STOP;
                res.done_res = 1'b1; res.error_code = ERR_SEND;
              end
            end
            PH_RX: begin
              if ((op_i.status == ST_DATA_ACK) || (op_i.status == ST_DATA_NACK)) begin
                res.rx_valid = 1'b1;
                res.rx_data  = op_i.data;
                res.rx_index = pos_q[2:0];
                pos_d        = pos_inc;
                left_d       = left_dec;
                if ((op_i.status == ST_DATA_NACK) || (left_dec == '0)) begin
                  phase_d = PH_IDLE; res.bus_command = CMD_STOP; res.done_res = 1'b1;
                  res.transferred = 4'(pos_inc);
                end else begin
                  res.bus_command = (left_dec == CNT_W'(1)) ? CMD_RXNACK : CMD_RXACK;
                end
              end else begin
                phase_d = PH_IDLE; res.bus_command = CMD_STOP;
                res.done_res = 1'b1; res.error_code = ERR_READ;
              end
            end
            default: begin
              // Data byte phase of a write transfer.
              if (ok) begin
                pos_d  = pos_inc;
                left_d = left_dec;
                if (left_dec != '0) begin
                  res.bus_command = CMD_SEND;
                  res.tx_byte     = wbuf_byte;
                end else begin
                  phase_d = PH_IDLE; res.bus_command = CMD_STOP; res.done_res = 1'b1;
                  res.transferred = 4'(pos_inc);
                end
              end else if (nack) begin
                phase_d = PH_IDLE; res.bus_command = CMD_STOP; res.done_res = 1'b1;
                res.transferred = 4'(pos_q);
              end else if (st_arb) begin
                left_d = total_q; pos_d = '0; phase_d = PH_START;
                res.bus_command = CMD_START;
              end else begin
                phase_d = PH_IDLE; res.bus_command = CMD_STOP;
                res.done_res = 1'b1; res.error_code = ERR_SEND;
              end
            end
          endcase
        end
        default: begin
        end
      endcase
    end
    res.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      is_read_q   <= 1'b0;
      attempt_q   <= '0;
      max_q       <= 4'(DEFAULT_ATTEMPTS);
      addr_q      <= '0;
      reg_q       <= '0;
      left_q      <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      is_read_q <= is_read_d;
      attempt_q <= attempt_d;
      addr_q    <= addr_d;
      reg_q     <= reg_d;
      left_q    <= left_d;
      total_q   <= total_d;
      pos_q     <= pos_d;
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
    if (pop_o && (op_i.kind == OP_LOAD) && op_i.load_en) begin
      wbuf_q[BUF_AW'(op_i.slot)] <= op_i.data;
    end
  end

  // The limit may be lowered between transfers, so only the lower bound is fixed.
  a_attempts_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (attempt_q != '0))
    else $error("transfer open without a counted attempt");

  a_left_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_q <= total_q) && (int'(total_q) <= MAX_BYTES))
    else $error("remaining byte count out of range");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res.done_res) |=> (out_valid_q && !out_q.busy_res && (phase_q == PH_IDLE)))
    else $error("completion reported while the transfer stays open");

  a_rx_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && res.rx_valid) |-> (phase_q == PH_RX))
    else $error("received byte reported outside the receive phase");

endmodule

// ===== hdl/i2c_master_register_transfer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_transfer
// I2C master register read/write sequencer driving a byte-level bus engine.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------
//   in      | input     | in_valid/in_ready  | in_data_i  (in_item_t)
//   out     | output    | out_valid/out_ready| out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i           | cfg_data_i (max_attempts)
//
// Every item yields one result; each item passes a queue entry and then the
// output register. One item per cycle is sustained while results are taken.
// The sequencer phase register is updated once per item, which sets that rate.
// A two-entry queue separates the front end from the sequencer, so input keeps
// being accepted while a result waits; input stalls when the queue is full.
// Reset is asynchronous and active low; no clearing pass follows it.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer import i2cmrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_data_i
);

  logic push, q_ready, q_valid, pop;
  op_t  push_op, pop_op;

  i2cmrt_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .q_ready_i  (q_ready),
    .op_o       (push_op)
  );

  i2cmrt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_op)
  );

  i2cmrt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .op_i        (pop_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/tb_i2c_master_register_transfer.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_master_register_transfer
// Self-checking testbench for the I2C master register transfer sequencer.
// A transaction-level model tracks the transfer phase, the attempt counter and
// the write buffer, and predicts each bus step. Each result is compared with
// the oldest prediction. Stimulus is a directed opening followed by random
// bus conversations, run under several attempt limits and flow-control mixes.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_transfer;
  import i2cmrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned IDLE_PLAN [NUM_PHASES]  = '{0, 51, 0, 12, 0, 12};
  localparam int unsigned STALL_PLAN [NUM_PHASES] = '{0, 0, 51, 12, 0, 12};
  localparam int unsigned ITEM_PLAN [NUM_PHASES]  = '{250, 250, 250, 100, 250, 250};
  localparam logic [3:0] ATTEMPT_PLAN [NUM_PHASES] = '{4'd1, 4'd15, 4'd2, 4'd0, 4'd0, 4'd10};
  localparam int unsigned RANDOM_LIMIT_PHASE = 4;
  localparam logic [2:0] ST_OTHER = 3'd7;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_ADDR_W,
    SEQ_REG,
    SEQ_RESTART,
    SEQ_ADDR_R,
    SEQ_RX,
    SEQ_TX
  } seq_phase_e;

  class xfer_model;
    logic [3:0] attempt_limit;
    seq_phase_e phase;
    logic       reading;
    logic [3:0] attempts;
    logic [6:0] target;
    logic [7:0] reg_index;
    logic [3:0] bytes_left;
    logic [3:0] byte_pos;
    logic [3:0] byte_total;
    logic [7:0] wbuf [MAX_BYTES];
    out_item_t  res;
    out_item_t  pending_steps [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned items_seen;
    int unsigned end_codes [8];

    function new();
      attempt_limit = 4'(DEFAULT_ATTEMPTS);
      phase = SEQ_IDLE;
      reading = 1'b0;
      attempts = '0;
      target = '0;
      reg_index = '0;
      bytes_left = '0;
      byte_pos = '0;
      byte_total = '0;
      foreach (wbuf[i]) wbuf[i] = '0;
      mismatches = 0;
      checked = 0;
      items_seen = 0;
      foreach (end_codes[i]) end_codes[i] = 0;
    endfunction

    function void set_limit(logic [3:0] value);
      attempt_limit = value;
    endfunction

    function void send_cmd(logic [7:0] b);
      res.bus_command = CMD_SEND;
      res.tx_byte = b;
    endfunction

    function void close_xfer(logic [2:0] cmd, logic [3:0] count, logic [2:0] err);
      res.bus_command = cmd;
      res.done_res = 1'b1;
      res.transferred = count;
      res.error_code = err;
      phase = SEQ_IDLE;
    endfunction

    function void reopen();
      bytes_left = byte_total;
      byte_pos = '0;
      phase = SEQ_START;
      res.bus_command = CMD_START;
      res.tx_byte = '0;
    endfunction

    function void try_attempt();
      if (attempts >= attempt_limit) begin
        close_xfer(CMD_NONE, '0, ERR_ATTEMPTS);
      end else begin
        attempts++;
        reopen();
      end
    endfunction

    function void next_receive();
      phase = SEQ_RX;
      res.bus_command = (bytes_left == 4'd1) ? CMD_RXNACK : CMD_RXACK;
    endfunction

    function void next_send();
      phase = SEQ_TX;
      send_cmd((byte_pos < MAX_BYTES) ? wbuf[byte_pos[BUF_AW-1:0]] : 8'h00);
    endfunction

    function void on_event(logic [2:0] st, logic [7:0] rx);
      bit ack;
      bit nack;
      bit opened;
      ack = (st == ST_ADDR_ACK) || (st == ST_DATA_ACK);
      nack = (st == ST_ADDR_NACK) || (st == ST_DATA_NACK);
      opened = (st == ST_START) || (st == ST_REPSTART);
      case (phase)
        SEQ_START: begin
          if (opened) begin
            phase = SEQ_ADDR_W;
            send_cmd({target, 1'b0});
          end else if (st == ST_ARB_LOST) reopen();
          else close_xfer(CMD_NONE, '0, ERR_START);
        end
        SEQ_ADDR_W: begin
          if (ack) begin
            phase = SEQ_REG;
            send_cmd(reg_index);
          end else if (nack) try_attempt();
          else if (st == ST_ARB_LOST) reopen();
          else close_xfer(CMD_STOP, '0, ERR_SEND);
        end
        SEQ_REG: begin
          if (ack) begin
            if (reading) begin
              phase = SEQ_RESTART;
              res.bus_command = CMD_START;
            end else if (bytes_left > 0) next_send();
            else close_xfer(CMD_STOP, '0, ERR_OK);
          end else if (nack) close_xfer(CMD_STOP, '0, ERR_OK);
          else if (st == ST_ARB_LOST) reopen();
          else close_xfer(CMD_STOP, '0, ERR_SEND);
        end
        SEQ_RESTART: begin
          if (opened) begin
            phase = SEQ_ADDR_R;
            send_cmd({target, 1'b1});
          end else if (st == ST_ARB_LOST) reopen();
          else close_xfer(CMD_STOP, '0, ERR_RESTART);
        end
        SEQ_ADDR_R: begin
          if (ack) begin
            if (bytes_left > 0) next_receive();
            else close_xfer(CMD_STOP, '0, ERR_OK);
          end else if (nack) close_xfer(CMD_STOP, '0, ERR_OK);
          else if (st == ST_ARB_LOST) reopen();
          else close_xfer(CMD_STOP, '0, ERR_SEND);
        end
        SEQ_RX: begin
          // Arbitration loss is not restartable once data is flowing in.
          if (st == ST_DATA_ACK || st == ST_DATA_NACK) begin
            res.rx_valid = 1'b1;
            res.rx_data = rx;
            res.rx_index = byte_pos[2:0];
            byte_pos++;
            if (bytes_left > 0) bytes_left--;
            if (st == ST_DATA_NACK || bytes_left == 0) close_xfer(CMD_STOP, byte_pos, ERR_OK);
            else next_receive();
          end else close_xfer(CMD_STOP, '0, ERR_READ);
        end
        SEQ_TX: begin
          if (ack) begin
            byte_pos++;
            if (bytes_left > 0) bytes_left--;
            if (bytes_left > 0) next_send();
            else close_xfer(CMD_STOP, byte_pos, ERR_OK);
          end else if (nack) close_xfer(CMD_STOP, byte_pos, ERR_OK);
          else if (st == ST_ARB_LOST) reopen();
          else close_xfer(CMD_STOP, '0, ERR_SEND);
        end
        default: phase = SEQ_IDLE;
      endcase
    endfunction

    function out_item_t next_step(in_item_t it);
      logic [3:0] cnt;
      res = '0;
      case (it.func)
        FUNC_LOAD: wbuf[it.load_index] = it.load_byte;
        FUNC_READ, FUNC_WRITE: begin
          // A start during a transfer is dropped without touching the state.
          if (phase == SEQ_IDLE) begin
            cnt = (it.byte_count > MAX_BYTES) ? 4'(MAX_BYTES) : it.byte_count;
            reading = (it.func == FUNC_READ);
            target = it.device_address;
            reg_index = it.register_address;
            byte_total = cnt;
            bytes_left = cnt;
            byte_pos = '0;
            attempts = '0;
            try_attempt();
          end
        end
        default: begin
          if (phase != SEQ_IDLE) on_event(it.bus_status, it.rx_byte);
        end
      endcase
      res.busy_res = (phase != SEQ_IDLE);
      return res;
    endfunction

    function void note_item(in_item_t it);
      pending_steps.push_back(next_step(it));
      items_seen++;
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task compare(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_step(out_item_t got);
      out_item_t want;
      if (pending_steps.size() == 0) begin
        report("result arrived with no transaction waiting for it");
      end else begin
        want = pending_steps.pop_front();
        checked++;
        if (want.done_res) end_codes[want.error_code]++;
        compare("bus_command", 8'(got.bus_command), 8'(want.bus_command));
        compare("tx_byte", got.tx_byte, want.tx_byte);
        compare("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
        compare("rx_data", got.rx_data, want.rx_data);
        compare("rx_index", 8'(got.rx_index), 8'(want.rx_index));
        compare("done_res", 8'(got.done_res), 8'(want.done_res));
        compare("transferred", 8'(got.transferred), 8'(want.transferred));
        compare("error_code", 8'(got.error_code), 8'(want.error_code));
        compare("busy_res", 8'(got.busy_res), 8'(want.busy_res));
      end
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_data_o;
  logic       cfg_we_i;
  logic [3:0] cfg_data_i;

  xfer_model   sb;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles;
  int unsigned cycle_count;

  i2c_master_register_transfer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, sb.pending_steps.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver side: a long hold-off takes priority over the random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_step(out_data_o);
  end

  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(it);
  endtask

  function automatic in_item_t background();
    logic [63:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic load_slot(input logic [2:0] idx, input logic [7:0] b);
    in_item_t it;
    it = background();
    it.func = FUNC_LOAD;
    it.load_index = idx;
    it.load_byte = b;
    send_item(it);
  endtask

  task automatic start_xfer(input logic [1:0] func, input logic [6:0] addr,
                            input logic [7:0] regi, input logic [3:0] cnt);
    in_item_t it;
    it = background();
    it.func = func;
    it.device_address = addr;
    it.register_address = regi;
    it.byte_count = cnt;
    send_item(it);
  endtask

  task automatic bus_event(input logic [2:0] st, input logic [7:0] rx);
    in_item_t it;
    it = background();
    it.func = FUNC_EVENT;
    it.bus_status = st;
    it.rx_byte = rx;
    send_item(it);
  endtask

  // Mostly the status a healthy bus engine would return in the current phase.
  function automatic logic [2:0] pick_status();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return 3'($urandom_range(7));
    case (sb.phase)
      SEQ_START, SEQ_RESTART: begin
        if (r < 12) return ST_ARB_LOST;
        return $urandom_range(1) ? ST_START : ST_REPSTART;
      end
      SEQ_ADDR_W: begin
        if (r < 30) return ST_ADDR_NACK;
        if (r < 34) return ST_ARB_LOST;
        return $urandom_range(1) ? ST_ADDR_ACK : ST_DATA_ACK;
      end
      SEQ_RX: begin
        if (r < 14) return ST_DATA_NACK;
        if (r < 16) return ST_ARB_LOST;
        return ST_DATA_ACK;
      end
      default: begin
        if (r < 12) return $urandom_range(1) ? ST_ADDR_NACK : ST_DATA_NACK;
        if (r < 15) return ST_ARB_LOST;
        return $urandom_range(1) ? ST_ADDR_ACK : ST_DATA_ACK;
      end
    endcase
  endfunction

  task automatic random_item(output bit counted);
    int unsigned pick;
    logic [3:0] cnt;
    pick = $urandom_range(99);
    counted = 1'b1;
    cnt = ($urandom_range(99) < 90) ? 4'($urandom_range(MAX_BYTES)) : 4'($urandom_range(15, 9));
    if (sb.phase == SEQ_IDLE) begin
      if (pick < 70) begin
        start_xfer($urandom_range(1) ? FUNC_READ : FUNC_WRITE, 7'($urandom), 8'($urandom), cnt);
      end else if (pick < 92) begin
        load_slot(3'($urandom), 8'($urandom));
      end else begin
        counted = 1'b0;
        bus_event(3'($urandom), 8'($urandom));
      end
    end else begin
      if (pick < 6) begin
        load_slot(3'($urandom), 8'($urandom));
      end else if (pick < 9) begin
        counted = 1'b0;
        start_xfer($urandom_range(1) ? FUNC_READ : FUNC_WRITE, 7'($urandom), 8'($urandom), cnt);
      end else begin
        bus_event(pick_status(), 8'($urandom));
      end
    end
  endtask

  // Lets every result drain, then waits for the pipeline to settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_steps.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_attempts(input logic [3:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(value);
  endtask

  task automatic set_rates(input int unsigned idle, input int unsigned stall);
    @(posedge clk_i);
    idle_pct = idle;
    stall_pct = stall;
  endtask

  initial begin
    int unsigned n;
    bit counted;
    logic [3:0] limit;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 0;
    cycle_count = 0;
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_attempts(4'd15);
    load_slot(3'd0, 8'h00);
    load_slot(3'd1, 8'hFF);
    load_slot(3'd2, 8'hA5);
    load_slot(3'd3, 8'h5A);
    load_slot(3'd4, 8'h01);
    load_slot(3'd5, 8'h80);
    load_slot(3'd6, 8'h7F);
    load_slot(3'd7, 8'hFE);
    bus_event(ST_DATA_ACK, 8'hFF);
    // Write transfer: address nack retry, arbitration loss, then a data nack.
    start_xfer(FUNC_WRITE, 7'h7F, 8'hFF, 4'd2);
    start_xfer(FUNC_READ, 7'h00, 8'h00, 4'd1);
    bus_event(ST_START, 8'h00);
    bus_event(ST_ADDR_NACK, 8'h00);
    bus_event(ST_REPSTART, 8'h00);
    bus_event(ST_ADDR_ACK, 8'h00);
    bus_event(ST_ARB_LOST, 8'h00);
    bus_event(ST_START, 8'h00);
    bus_event(ST_DATA_ACK, 8'h00);
    bus_event(ST_ADDR_ACK, 8'h00);
    bus_event(ST_DATA_ACK, 8'h00);
    bus_event(ST_DATA_NACK, 8'h00);
    // Read transfer with an oversized count, cut short by the host nack.
    start_xfer(FUNC_READ, 7'h00, 8'h00, 4'd15);
    bus_event(ST_START, 8'h00);
    bus_event(ST_ADDR_ACK, 8'h00);
    bus_event(ST_DATA_ACK, 8'h00);
    bus_event(ST_REPSTART, 8'h00);
    bus_event(ST_ADDR_ACK, 8'h00);
    bus_event(ST_DATA_ACK, 8'hFF);
    bus_event(ST_DATA_NACK, 8'h00);
    bus_event(ST_OTHER, 8'h00);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      limit = (p == RANDOM_LIMIT_PHASE) ? 4'($urandom_range(2, 14)) : ATTEMPT_PLAN[p];
      write_attempts(limit);
      set_rates(IDLE_PLAN[p], STALL_PLAN[p]);
      // Backpressure burst: the output stalls long enough to fill the queue.
      if (p == 0) hold_cycles = 80;
      n = 0;
      while (n < ITEM_PLAN[p]) begin
        random_item(counted);
        n += counted;
      end
      wait_drained();
    end

    $display("Checked %0d results for %0d input transactions over %0d random phases.",
             sb.checked, sb.items_seen, NUM_PHASES);
    $display("Transfer endings: ok %0d, start %0d, restart %0d, send %0d, read %0d, attempts %0d.",
             sb.end_codes[ERR_OK], sb.end_codes[ERR_START], sb.end_codes[ERR_RESTART],
             sb.end_codes[ERR_SEND], sb.end_codes[ERR_READ], sb.end_codes[ERR_ATTEMPTS]);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches found.", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
